>>> rtl/pif_pkg.sv
// Shared types and constants for the integer field formatter.
`timescale 1ns / 1ps
package pif_pkg;

	localparam logic [2:0] CONV_SDEC  = 3'd0;
	localparam logic [2:0] CONV_UDEC  = 3'd1;
	localparam logic [2:0] CONV_OCT   = 3'd2;
	localparam logic [2:0] CONV_HEXL  = 3'd3;
	localparam logic [2:0] CONV_HEXU  = 3'd4;

	localparam logic [2:0] LMOD_INT    = 3'd0;
	localparam logic [2:0] LMOD_CHAR   = 3'd1;
	localparam logic [2:0] LMOD_SHORT  = 3'd2;
	localparam logic [2:0] LMOD_LONG   = 3'd3;
	localparam logic [2:0] LMOD_LLONG  = 3'd4;
	localparam logic [2:0] LMOD_INTMAX = 3'd5;
	localparam logic [2:0] LMOD_SIZE   = 3'd6;

	// Decimal digits needed for any 64-bit magnitude.
	localparam int NDEC = 20;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_LX    = 8'd120;
	localparam logic [7:0] CH_UX    = 8'd88;
	localparam logic [7:0] CH_LA_OFS = 8'd87;
	localparam logic [7:0] CH_UA_OFS = 8'd55;

	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  conversion;
		logic [2:0]  length_mod;
		logic        left_align;
		logic        force_sign;
		logic        space_sign;
		logic        zero_pad;
		logic        alt_form;
		logic [5:0]  field_width;
		logic        has_precision;
		logic [5:0]  precision_value;
	} pif_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} pif_out_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // capture a new argument
		logic conv_step; // one shift of the binary to decimal conversion
		logic count;     // count the digits to print
		logic plan;      // compute the field layout
		logic emit;      // present the next character
	} pif_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic conv_last; // the current step finishes the conversion
		logic field_end; // the character now presented is the last one
		logic empty;     // the field has no characters
	} pif_sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		begin
			if (d < 4'd10) r = CH_ZERO + {4'd0, d};
			else if (upper) r = CH_UA_OFS + {4'd0, d};
			else r = CH_LA_OFS + {4'd0, d};
			return r;
		end
	endfunction

endpackage

>>> rtl/pif_datapath.sv
// Datapath of the integer field formatter: digit conversion, layout, emission.
`timescale 1ns / 1ps
module pif_datapath #(
	parameter int MAX_DIGITS = 22,
	parameter int MAX_WIDTH  = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pif_pkg::pif_in_t  in_word,
	input  pif_pkg::pif_cmd_t cmd,
	output pif_pkg::pif_sts_t sts,
	output logic [7:0]        char_out
);
	import pif_pkg::*;

	localparam int DW = $clog2(MAX_DIGITS + 1);
	localparam int IW = $clog2(MAX_DIGITS);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = WW + 2;

	logic [63:0] mag_q;     // magnitude after truncation and sign removal
	logic [63:0] sh_q;      // bits still to be shifted into the decimal register
	logic [4*NDEC-1:0] bcd_q;
	logic [5:0]  step_q;
	logic        upper_q, left_q, zflag_q, hasp_q, alt_q, oct_q, hex_q;
	logic [7:0]  sign_q;
	logic [WW-1:0] width_q, prec_q;
	logic [DW-1:0] nd_q;
	logic [CW-1:0] pad_q, zeros_q, prefix_q, signc_q;
	logic [DW-1:0] left_digs_q;
	logic [CW-1:0] trail_q;

	// Argument decode on load.
	logic [63:0] tv;
	logic [WW-1:0] w_cl, p_cl;
	logic [2:0] cv;
	logic [7:0] sg;
	always_comb begin
		cv = (in_word.conversion > CONV_HEXU) ? CONV_UDEC : in_word.conversion;
		tv = in_word.value;
		unique case (in_word.length_mod)
			LMOD_INT:   tv = (cv == CONV_SDEC) ? {{32{tv[31]}}, tv[31:0]} : {32'd0, tv[31:0]};
			LMOD_CHAR:  tv = (cv == CONV_SDEC) ? {{56{tv[7]}}, tv[7:0]} : {56'd0, tv[7:0]};
			LMOD_SHORT: tv = (cv == CONV_SDEC) ? {{48{tv[15]}}, tv[15:0]} : {48'd0, tv[15:0]};
			default:    tv = in_word.value;
		endcase
		sg = 8'd0;
		if (cv == CONV_SDEC) begin
			if (tv[63]) begin
				sg = CH_MINUS;
				tv = 64'd0 - tv;
			end else if (in_word.force_sign) sg = CH_PLUS;
			else if (in_word.space_sign) sg = CH_SPACE;
		end
		w_cl = ({2'd0, in_word.field_width} > 8'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
			: WW'(in_word.field_width);
		p_cl = ({2'd0, in_word.precision_value} > 8'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
			: WW'(in_word.precision_value);
	end

	// Shift-and-add-3 conversion: each decimal digit of five or more gets 3
	// added before the next magnitude bit is shifted in.
	logic [4*NDEC-1:0] bcd_adj;
	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	// Digit string, least significant first. Octal and hex digits are plain
	// slices of the magnitude.
	logic [3:0] digs [MAX_DIGITS];
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (hex_q) digs[i] = 4'(mag_q >> (4 * i));
			else if (oct_q) digs[i] = {1'b0, 3'(mag_q >> (3 * i))};
			else digs[i] = 4'(bcd_q >> (4 * i));
		end
	end

	// Printed digit count: up to the highest nonzero digit, at least one,
	// and none for a zero value with precision zero.
	logic [DW-1:0] nd_c;
	always_comb begin
		nd_c = DW'(1);
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (digs[i] != 4'd0) nd_c = DW'(i + 1);
		end
		if (hasp_q && prec_q == '0 && mag_q == 64'd0) nd_c = '0;
	end

	// Layout from the finished digit string.
	logic [CW-1:0] z0, pf, tot, zf, pd;
	always_comb begin
		z0 = (hasp_q && CW'(prec_q) > CW'(nd_q)) ? CW'(prec_q) - CW'(nd_q) : '0;
		if (oct_q && alt_q && z0 == '0
			&& (nd_q == '0 || digs[IW'(nd_q - DW'(1))] != 4'd0))
			z0 = CW'(1);
		pf = (hex_q && alt_q && mag_q != 64'd0) ? CW'(2) : '0;
		tot = CW'(sign_q != 8'd0) + pf + z0 + CW'(nd_q);
		zf = z0;
		if (zflag_q && !left_q && !hasp_q && CW'(width_q) > tot) begin
			zf = z0 + CW'(width_q) - tot;
			tot = CW'(width_q);
		end
		pd = (CW'(width_q) > tot) ? CW'(width_q) - tot : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q   <= '0;
			sh_q    <= '0;
			bcd_q   <= '0;
			step_q  <= '0;
			upper_q <= 1'b0;
			oct_q   <= 1'b0;
			hex_q   <= 1'b0;
			left_q  <= 1'b0;
			zflag_q <= 1'b0;
			hasp_q  <= 1'b0;
			alt_q   <= 1'b0;
			sign_q  <= '0;
			width_q <= '0;
			prec_q  <= '0;
			nd_q    <= '0;
			pad_q   <= '0;
			trail_q <= '0;
			signc_q <= '0;
			prefix_q <= '0;
			zeros_q <= '0;
			left_digs_q <= '0;
		end else if (cmd.load) begin
			mag_q   <= tv;
			sh_q    <= tv;
			bcd_q   <= '0;
			step_q  <= '0;
			upper_q <= cv == CONV_HEXU;
			oct_q   <= cv == CONV_OCT;
			hex_q   <= cv >= CONV_HEXL;
			left_q  <= in_word.left_align;
			zflag_q <= in_word.zero_pad;
			hasp_q  <= in_word.has_precision;
			alt_q   <= in_word.alt_form;
			sign_q  <= sg;
			width_q <= w_cl;
			prec_q  <= p_cl;
			nd_q    <= '0;
		end else if (cmd.conv_step) begin
			bcd_q  <= {bcd_adj[4*NDEC-2:0], sh_q[63]};
			sh_q   <= {sh_q[62:0], 1'b0};
			step_q <= step_q + 6'd1;
		end else if (cmd.count) begin
			nd_q <= nd_c;
		end else if (cmd.plan) begin
			pad_q   <= left_q ? '0 : pd;
			trail_q <= left_q ? pd : '0;
			signc_q <= CW'(sign_q != 8'd0);
			prefix_q <= pf;
			zeros_q <= zf;
			left_digs_q <= nd_q;
		end else if (cmd.emit) begin
			if (pad_q != '0) pad_q <= pad_q - CW'(1);
			else if (signc_q != '0) signc_q <= '0;
			else if (prefix_q != '0) prefix_q <= prefix_q - CW'(1);
			else if (zeros_q != '0) zeros_q <= zeros_q - CW'(1);
			else if (left_digs_q != '0) left_digs_q <= left_digs_q - DW'(1);
			else if (trail_q != '0) trail_q <= trail_q - CW'(1);
		end
	end

	always_comb begin
		if (pad_q != '0) char_out = CH_SPACE;
		else if (signc_q != '0) char_out = sign_q;
		else if (prefix_q == CW'(2)) char_out = CH_ZERO;
		else if (prefix_q != '0) char_out = upper_q ? CH_UX : CH_LX;
		else if (zeros_q != '0) char_out = CH_ZERO;
		else if (left_digs_q != '0)
			char_out = digit_char(digs[IW'(left_digs_q - DW'(1))], upper_q);
		else char_out = CH_SPACE;
	end

	logic [CW+1:0] remaining;
	assign remaining = (CW+2)'(pad_q) + (CW+2)'(signc_q) + (CW+2)'(prefix_q)
		+ (CW+2)'(zeros_q) + (CW+2)'(left_digs_q) + (CW+2)'(trail_q);

	assign sts.conv_last = step_q == 6'd63;
	assign sts.field_end = remaining == (CW+2)'(1);
	assign sts.empty     = remaining == '0;
endmodule

>>> rtl/pif_control.sv
// Controller state machine of the integer field formatter.
`timescale 1ns / 1ps
module pif_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              out_last,
	input  pif_pkg::pif_sts_t sts,
	output pif_pkg::pif_cmd_t cmd
);
	import pif_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_CNT  = 3'd2;
	localparam logic [2:0] ST_PLAN = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0] state_q;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = state_q == ST_EMIT;
	assign out_last  = sts.field_end;

	always_comb begin
		cmd = '0;
		cmd.load      = state_q == ST_IDLE && in_valid;
		cmd.conv_step = state_q == ST_CONV;
		cmd.count     = state_q == ST_CNT;
		cmd.plan      = state_q == ST_PLAN;
		cmd.emit      = state_q == ST_EMIT && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CONV;
				ST_CONV: if (sts.conv_last) state_q <= ST_CNT;
				ST_CNT: state_q <= ST_PLAN;
				ST_PLAN: state_q <= ST_CHK;
				ST_CHK: state_q <= sts.empty ? ST_IDLE : ST_EMIT;
				ST_EMIT: if (!out_stall && sts.field_end) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/printf_integer_formatter.sv
// Top level of the printf-style integer field formatter.
// Sequence: conversion steps, then the digit count, layout and check states; after the
// check state the characters follow, one per cycle while out_stall is low.
// One argument at a time: in_stall stays high until the whole field has been emitted.
// A field with no characters ends in the check state without any output word.
// Reset (arst_n low) returns the controller to idle and clears the datapath at once.
`timescale 1ns / 1ps
module printf_integer_formatter #(
	parameter int MAX_DIGITS = 22,
	parameter int MAX_WIDTH  = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pif_pkg::pif_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output pif_pkg::pif_out_t out_data
);
	import pif_pkg::*;

	pif_cmd_t   cmd;
	pif_sts_t   sts;
	logic [7:0] ch;
	logic       last;

	// The datapath holds the argument, the digit string and the emission counters.
	pif_datapath #(.MAX_DIGITS(MAX_DIGITS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_data), .cmd(cmd), .sts(sts), .char_out(ch)
	);

	// The controller sequences conversion, layout and character output.
	pif_control u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .out_last(last), .sts(sts), .cmd(cmd)
	);

	assign out_data.out_char = ch;
	assign out_data.out_last = last;
endmodule

>>> rtl/pif_checker.sv
// Port-level checker for the integer field formatter, with its bind.
`timescale 1ns / 1ps
module pif_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input pif_pkg::pif_out_t out_data
);
	import pif_pkg::*;

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while emitting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output changed");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.out_last |=> !out_valid)
		else $error("output continued after last");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("not busy after accept");
endmodule

bind printf_integer_formatter pif_checker u_pif_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

>>> dv/tb_printf_integer_formatter.sv
// Self-checking testbench for the printf-style integer field formatter.
`timescale 1ns / 1ps
module tb_printf_integer_formatter;
	import pif_pkg::*;

	// The drain runs long after the last expectation is met, so that any
	// stray character words still show up as mismatches.
	localparam int DRAIN_CYCLES = 2000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	pif_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	pif_out_t out_data;

	// Characters still owed by the block, oldest first.
	pif_out_t pending_chars[$];
	int       error_count;
	// When set, neither side inserts gaps or stalls.
	logic     steady_flow;

	printf_integer_formatter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous limit: every item at its slowest with long receiver stalls.
	initial begin
		#30ms;
		$display("FAIL printf_integer_formatter");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// Builds the expected field for one argument, one character per word,
	// following the standard C printf rules for integer conversions.
	function automatic void format_field(input pif_in_t w);
		logic [63:0] v;
		logic [63:0] mask;
		logic [63:0] t;
		logic [2:0]  conv;
		logic [7:0]  sign_ch;
		logic [7:0]  digs[22];
		logic [7:0]  chars[$];
		logic        upper;
		pif_out_t    r;
		int          bits, base, width, prec, nd, zeros, prefix, total, pad, d;
		width = (w.field_width > 40) ? 40 : int'(w.field_width);
		prec = (w.precision_value > 40) ? 40 : int'(w.precision_value);
		conv = (w.conversion > CONV_HEXU) ? CONV_UDEC : w.conversion;
		case (w.length_mod)
			LMOD_INT:   bits = 32;
			LMOD_CHAR:  bits = 8;
			LMOD_SHORT: bits = 16;
			default:    bits = 64;
		endcase
		v = w.value;
		if (bits < 64) begin
			mask = (64'd1 << bits) - 64'd1;
			v &= mask;
			if (conv == CONV_SDEC && v[bits-1])
				v |= ~mask;
		end
		sign_ch = 8'd0;
		if (conv == CONV_SDEC) begin
			if (v[63]) begin
				sign_ch = CH_MINUS;
				v = 64'd0 - v;
			end else if (w.force_sign) begin
				sign_ch = CH_PLUS;
			end else if (w.space_sign) begin
				sign_ch = CH_SPACE;
			end
		end
		base = (conv == CONV_OCT) ? 8 : (conv >= CONV_HEXL) ? 16 : 10;
		upper = (conv == CONV_HEXU);
		nd = 0;
		if (!(w.has_precision && prec == 0 && v == 64'd0)) begin
			t = v;
			do begin
				d = int'(t % base);
				if (d < 10) digs[nd] = CH_ZERO + 8'(d);
				else digs[nd] = (upper ? CH_UA_OFS : CH_LA_OFS) + 8'(d);
				nd++;
				t = t / base;
			end while (t != 64'd0 && nd < 22);
		end
		zeros = (w.has_precision && prec > nd) ? prec - nd : 0;
		// Octal alternate form needs a leading zero unless one is there.
		if (conv == CONV_OCT && w.alt_form && zeros == 0 && (nd == 0 || digs[nd-1] != CH_ZERO))
			zeros = 1;
		prefix = (conv >= CONV_HEXL && w.alt_form && v != 64'd0) ? 2 : 0;
		total = (sign_ch != 8'd0 ? 1 : 0) + prefix + zeros + nd;
		if (w.zero_pad && !w.left_align && !w.has_precision && width > total) begin
			zeros += width - total;
			total = width;
		end
		pad = (width > total) ? width - total : 0;
		if (!w.left_align) repeat (pad) chars.push_back(CH_SPACE);
		if (sign_ch != 8'd0) chars.push_back(sign_ch);
		if (prefix != 0) begin
			chars.push_back(CH_ZERO);
			chars.push_back(upper ? CH_UX : CH_LX);
		end
		repeat (zeros) chars.push_back(CH_ZERO);
		for (int i = nd - 1; i >= 0; i--) chars.push_back(digs[i]);
		if (w.left_align) repeat (pad) chars.push_back(CH_SPACE);
		foreach (chars[i]) begin
			r.out_char = chars[i];
			r.out_last = (i == chars.size() - 1);
			pending_chars.push_back(r);
		end
	endfunction

	// Short gaps are common; now and then a long one.
	function automatic int idle_length();
		if (steady_flow) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(40, 10);
		return ($urandom_range(2) == 0) ? 0 : $urandom_range(3);
	endfunction

	// Presents one argument word at a falling edge and holds it until the
	// block takes it; the expected field is queued at the accepting edge.
	task automatic send_argument(input pif_in_t w);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = w;
		do @(posedge clk); while (in_stall);
		format_field(w);
	endtask

	// Receiver stall: runs of stall cycles of random length.
	initial begin
		int run;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			run = idle_length();
			if (run > 0) begin
				out_stall = 1'b1;
				repeat (run) @(negedge clk);
			end
			out_stall = 1'b0;
		end
	end

	// Compares each accepted character word with the oldest expectation.
	always @(posedge clk) begin
		pif_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected word char=%0d last=%0b",
					out_data.out_char, out_data.out_last));
			end else begin
				want = pending_chars.pop_front();
				if (out_data.out_char !== want.out_char)
					report_mismatch($sformatf("char got %0d want %0d",
						out_data.out_char, want.out_char));
				if (out_data.out_last !== want.out_last)
					report_mismatch($sformatf("last got %0b want %0b",
						out_data.out_last, want.out_last));
			end
		end
	end

	function automatic pif_in_t make_arg(input logic [63:0] v, input logic [2:0] conv,
			input logic [2:0] lmod, input logic [4:0] flags, input int width,
			input int hasp, input int prec);
		pif_in_t w;
		w.value = v;
		w.conversion = conv;
		w.length_mod = lmod;
		{w.left_align, w.force_sign, w.space_sign, w.zero_pad, w.alt_form} = flags;
		w.field_width = 6'(width);
		w.has_precision = (hasp != 0);
		w.precision_value = 6'(prec);
		return w;
	endfunction

	// Flag bit order: left, plus, space, zero, alternate.
	task automatic test_extremes();
		send_argument(make_arg(64'h8000_0000_0000_0000, CONV_SDEC, LMOD_LONG, 5'b00000, 0, 0, 0));
		send_argument(make_arg(64'hFFFF_FFFF_FFFF_FFFF, CONV_UDEC, LMOD_LLONG, 5'b00000, 0, 0, 0));
		send_argument(make_arg(64'hFFFF_FFFF_FFFF_FFFF, CONV_OCT, LMOD_INTMAX, 5'b00001, 0, 0, 0));
		send_argument(make_arg(64'h0000_0000_8000_0000, CONV_SDEC, LMOD_INT, 5'b01000, 12, 0, 0));
		send_argument(make_arg(64'h1234_5678_0000_0080, CONV_SDEC, LMOD_CHAR, 5'b00000, 0, 0, 0));
		send_argument(make_arg(64'hABCD_0000_0000_8000, CONV_SDEC, LMOD_SHORT, 5'b00000, 0, 0, 0));
		send_argument(make_arg(64'hDEAD_BEEF_CAFE_F00D, CONV_HEXU, LMOD_SIZE, 5'b00001, 63, 1, 63));
		send_argument(make_arg(64'h7FFF_FFFF_FFFF_FFFF, CONV_SDEC, 3'd7, 5'b10000, 40, 0, 0));
	endtask

	task automatic test_flags();
		send_argument(make_arg(64'd42, CONV_SDEC, LMOD_INT, 5'b01000, 6, 0, 0));
		send_argument(make_arg(64'd42, CONV_SDEC, LMOD_INT, 5'b00100, 6, 0, 0));
		send_argument(make_arg(64'd42, CONV_SDEC, LMOD_INT, 5'b11111, 8, 0, 0));
		send_argument(make_arg(-64'sd42, CONV_SDEC, LMOD_INT, 5'b00010, 8, 0, 0));
		send_argument(make_arg(64'h2F, CONV_HEXL, LMOD_INT, 5'b00011, 9, 0, 0));
		send_argument(make_arg(64'h2F, CONV_HEXU, LMOD_INT, 5'b10001, 9, 1, 5));
		send_argument(make_arg(64'd8, CONV_OCT, LMOD_INT, 5'b00011, 7, 1, 3));
		send_argument(make_arg(64'd77, CONV_UDEC, LMOD_INT, 5'b01100, 5, 0, 0));
	endtask

	task automatic test_special_cases();
		// Empty field: zero, precision zero, nothing else printed.
		send_argument(make_arg(64'd0, CONV_SDEC, LMOD_INT, 5'b00000, 0, 1, 0));
		// Zero with precision zero but a width still gives padding.
		send_argument(make_arg(64'd0, CONV_HEXL, LMOD_INT, 5'b00001, 4, 1, 0));
		// Octal alternate form of zero with precision zero prints one zero.
		send_argument(make_arg(64'd0, CONV_OCT, LMOD_INT, 5'b00001, 0, 1, 0));
		// Unknown conversion codes act as unsigned decimal.
		send_argument(make_arg(64'hFFFF_FFFF, 3'd5, LMOD_INT, 5'b01000, 0, 0, 0));
		send_argument(make_arg(64'd123, 3'd7, 3'd7, 5'b00000, 50, 1, 45));
		// Alternate hex of zero has no prefix.
		send_argument(make_arg(64'd0, CONV_HEXU, LMOD_INT, 5'b00011, 5, 0, 0));
	endtask

	task automatic test_random(input int count);
		pif_in_t w;
		for (int n = 0; n < count; n++) begin
			// Change the idling pattern now and then, including idle-free stretches.
			if (n % 40 == 0) steady_flow = ($urandom_range(3) == 0);
			w = pif_in_t'({$urandom, $urandom, $urandom, $urandom});
			case ($urandom_range(4))
				0: w.value = 64'($urandom_range(20));
				1: w.value = {$urandom, $urandom} >> $urandom_range(63);
				2: w.value = ~(64'($urandom_range(300)));
				default: ;
			endcase
			w.conversion = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4));
			// Mostly modest widths; the upper range tests clamping.
			if ($urandom_range(3) != 0) w.field_width = 6'($urandom_range(12));
			if ($urandom_range(3) != 0) w.precision_value = 6'($urandom_range(8));
			send_argument(w);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		error_count = 0;
		steady_flow = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_flags();
		test_special_cases();
		test_random(230);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS printf_integer_formatter");
		else
			$display("FAIL printf_integer_formatter");
		$finish;
	end

endmodule
